// ----- rtl/jsu_pkg.sv -----
// ----------------------------------------------------------------------------
// JSON string unescaper package
// Shared decode-mode codes, status codes and the types that pass between
// the decoder and the top level.
// ----------------------------------------------------------------------------
package jsu_pkg;

   // Decoder modes. While an error is pending the mode field holds the status.
   localparam logic [2:0] MODE_PLAIN   = 3'd0;
   localparam logic [2:0] MODE_ESC     = 3'd1;
   localparam logic [2:0] MODE_HEX1    = 3'd2;
   localparam logic [2:0] MODE_WAIT_BS = 3'd3;
   localparam logic [2:0] MODE_WAIT_U  = 3'd4;
   localparam logic [2:0] MODE_HEX2    = 3'd5;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_BAD_ESC   = 3'd1;
   localparam logic [2:0] STATUS_BAD_HEX   = 3'd2;
   localparam logic [2:0] STATUS_SURROGATE = 3'd3;
   localparam logic [2:0] STATUS_TRUNCATED = 3'd4;

   // Most results one input byte can produce.
   localparam int MAX_RESULTS = 4;

   typedef struct packed {
      logic [2:0]  mode;
      logic [1:0]  hex_count;
      logic [15:0] code_accum;
      logic [9:0]  high_half;
      logic        error_seen;
   } dec_state_type;

   localparam dec_state_type STATE_RESET = '{
      mode:       MODE_PLAIN,
      hex_count:  2'd0,
      code_accum: 16'd0,
      high_half:  10'd0,
      error_seen: 1'b0
   };

   // The results caused by one input byte, in output order.
   typedef struct packed {
      logic [2:0]                   count;
      logic [MAX_RESULTS-1:0][7:0]  data;
      logic [MAX_RESULTS-1:0]       valid;
      logic [MAX_RESULTS-1:0][2:0]  status;
      logic                         eos;
   } bundle_type;

endpackage

// ----- rtl/jsu_if.sv -----
// ----------------------------------------------------------------------------
// JSON string unescaper channels
// Valid/ready interfaces for the raw byte channel and the result channel.
// ----------------------------------------------------------------------------
interface jsu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_string;

   modport source (output valid, output in_byte, output end_of_string, input ready);
   modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface jsu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       run_last;
   logic       string_done;
   logic [2:0] status;

   modport source (output valid, output out_byte, output byte_valid, output run_last,
                   output string_done, output status, input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input run_last,
                   input string_done, input status, output ready);
endinterface

// ----- rtl/jsu_decoder.sv -----
// ----------------------------------------------------------------------------
// JSON string unescaper decoder
// Combinational step of the escape decoder: from the current state and one
// raw byte it forms the next state and the bundle of up to four results.
// ----------------------------------------------------------------------------
module jsu_decoder
   import jsu_pkg::*;
(
   input  dec_state_type cur_state,
   input  logic [7:0]    in_byte,
   input  logic          end_of_string,
   output dec_state_type next_state,
   output bundle_type    bundle
);

   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_SLASH  = 8'h2F;
   localparam logic [7:0] CHAR_B      = 8'h62;
   localparam logic [7:0] CHAR_F      = 8'h66;
   localparam logic [7:0] CHAR_N      = 8'h6E;
   localparam logic [7:0] CHAR_R      = 8'h72;
   localparam logic [7:0] CHAR_T      = 8'h74;
   localparam logic [7:0] CHAR_U      = 8'h75;

   // Returns {is_hex, value}.
   function automatic logic [4:0] hex_value(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, b[3:0]};
      end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
         r = {1'b1, b[3:0] + 4'd9};
      end
      return r;
   endfunction

   logic [4:0]  hexv;
   logic [15:0] acc_shift;
   logic [20:0] cp_pair;
   logic        failed;
   logic [2:0]  eos_status;

   assign hexv      = hex_value(in_byte);
   assign acc_shift = {cur_state.code_accum[11:0], hexv[3:0]};
   assign cp_pair   = {1'b0, cur_state.high_half, acc_shift[9:0]} + 21'h10000;

   always_comb begin
      next_state = cur_state;
      bundle     = '0;
      failed     = 1'b0;
      eos_status = STATUS_OK;

      if (cur_state.error_seen) begin
         // Bytes after an error are dropped; the end reports the stored code.
         if (end_of_string) begin
            bundle.count     = 3'd1;
            bundle.status[0] = cur_state.mode;
            failed           = 1'b1;
         end
      end else begin
         unique case (cur_state.mode)
            MODE_ESC: begin
               next_state.mode = MODE_PLAIN;
               bundle.count    = 3'd1;
               bundle.valid[0] = 1'b1;
               unique case (in_byte)
                  CHAR_QUOTE, CHAR_BSLASH, CHAR_SLASH: bundle.data[0] = in_byte;
                  CHAR_B: bundle.data[0] = 8'h08;
                  CHAR_F: bundle.data[0] = 8'h0C;
                  CHAR_N: bundle.data[0] = 8'h0A;
                  CHAR_R: bundle.data[0] = 8'h0D;
                  CHAR_T: bundle.data[0] = 8'h09;
                  CHAR_U: begin
                     bundle.count          = 3'd0;
                     bundle.valid[0]       = 1'b0;
                     next_state.mode       = MODE_HEX1;
                     next_state.hex_count  = 2'd0;
                     next_state.code_accum = 16'd0;
                  end
                  default: begin
                     bundle.valid[0]       = 1'b0;
                     bundle.status[0]      = STATUS_BAD_ESC;
                     next_state.error_seen = 1'b1;
                     next_state.mode       = STATUS_BAD_ESC;
                     failed                = 1'b1;
                  end
               endcase
            end
            MODE_HEX1, MODE_HEX2: begin
               if (!hexv[4]) begin
                  bundle.count          = 3'd1;
                  bundle.status[0]      = STATUS_BAD_HEX;
                  next_state.error_seen = 1'b1;
                  next_state.mode       = STATUS_BAD_HEX;
                  failed                = 1'b1;
               end else begin
                  next_state.code_accum = acc_shift;
                  if (cur_state.hex_count != 2'd3) begin
                     next_state.hex_count = cur_state.hex_count + 2'd1;
                  end else begin
                     next_state.hex_count = 2'd0;
                     if (cur_state.mode == MODE_HEX1) begin
                        if (acc_shift[15:10] == 6'b110110) begin
                           // High surrogate: wait for the low half.
                           next_state.high_half = acc_shift[9:0];
                           next_state.mode      = MODE_WAIT_BS;
                        end else begin
                           next_state.mode = MODE_PLAIN;
                           if (acc_shift[15:7] == 9'd0) begin
                              bundle.count   = 3'd1;
                              bundle.valid   = 4'b0001;
                              bundle.data[0] = {1'b0, acc_shift[6:0]};
                           end else if (acc_shift[15:11] == 5'd0) begin
                              bundle.count   = 3'd2;
                              bundle.valid   = 4'b0011;
                              bundle.data[0] = {3'b110, acc_shift[10:6]};
                              bundle.data[1] = {2'b10, acc_shift[5:0]};
                           end else begin
                              bundle.count   = 3'd3;
                              bundle.valid   = 4'b0111;
                              bundle.data[0] = {4'b1110, acc_shift[15:12]};
                              bundle.data[1] = {2'b10, acc_shift[11:6]};
                              bundle.data[2] = {2'b10, acc_shift[5:0]};
                           end
                        end
                     end else begin
                        if (acc_shift[15:10] == 6'b110111) begin
                           next_state.mode = MODE_PLAIN;
                           bundle.count    = 3'd4;
                           bundle.valid    = 4'b1111;
                           bundle.data[0]  = {5'b11110, cp_pair[20:18]};
                           bundle.data[1]  = {2'b10, cp_pair[17:12]};
                           bundle.data[2]  = {2'b10, cp_pair[11:6]};
                           bundle.data[3]  = {2'b10, cp_pair[5:0]};
                        end else begin
                           bundle.count          = 3'd1;
                           bundle.status[0]      = STATUS_SURROGATE;
                           next_state.error_seen = 1'b1;
                           next_state.mode       = STATUS_SURROGATE;
                           failed                = 1'b1;
                        end
                     end
                  end
               end
            end
            MODE_WAIT_BS, MODE_WAIT_U: begin
               if (cur_state.mode == MODE_WAIT_BS && in_byte == CHAR_BSLASH) begin
                  next_state.mode = MODE_WAIT_U;
               end else if (cur_state.mode == MODE_WAIT_U && in_byte == CHAR_U) begin
                  next_state.mode       = MODE_HEX2;
                  next_state.hex_count  = 2'd0;
                  next_state.code_accum = 16'd0;
               end else begin
                  bundle.count          = 3'd1;
                  bundle.status[0]      = STATUS_SURROGATE;
                  next_state.error_seen = 1'b1;
                  next_state.mode       = STATUS_SURROGATE;
                  failed                = 1'b1;
               end
            end
            default: begin
               // Plain text, and any unused mode code.
               if (in_byte == CHAR_BSLASH) begin
                  next_state.mode = MODE_ESC;
               end else begin
                  next_state.mode = MODE_PLAIN;
                  bundle.count    = 3'd1;
                  bundle.valid[0] = 1'b1;
                  bundle.data[0]  = in_byte;
               end
            end
         endcase
      end

      if (end_of_string) begin
         if (!failed) begin
            if (next_state.mode == MODE_HEX1 || next_state.mode == MODE_WAIT_U ||
                next_state.mode == MODE_HEX2) begin
               eos_status = STATUS_TRUNCATED;
            end else if (next_state.mode == MODE_WAIT_BS) begin
               eos_status = STATUS_SURROGATE;
            end
            // A nonzero status only arises from modes that produced no bytes,
            // so the status result always lands in the first slot.
            if (eos_status != STATUS_OK || bundle.count == 3'd0) begin
               bundle.count     = 3'd1;
               bundle.valid[0]  = 1'b0;
               bundle.data[0]   = 8'd0;
               bundle.status[0] = eos_status;
            end
         end
         next_state = STATE_RESET;
      end
      bundle.eos = end_of_string;
   end

endmodule

// ----- rtl/json_string_unescaper_top.sv -----
// ----------------------------------------------------------------------------
// JSON string unescaper
// Streams the body of a JSON string and returns unescaped UTF-8 bytes.
// ----------------------------------------------------------------------------
// The req_chan channel takes one raw byte per transaction, with end_of_string
// set on the final byte of a string. The rsp_chan channel returns one result
// per transaction: a UTF-8 byte (byte_valid 1) or a status-only result.
// run_last marks the last result caused by an input byte, and string_done
// marks the last result of the whole string.
// Each input byte is decoded in the cycle it is accepted and its results are
// loaded into a result bundle register, so the first result appears in the
// cycle after acceptance. The bundle is emitted one result per cycle while the
// receiver is ready: a byte that yields n results (0 to 4) holds the output
// until its last result is taken, and a new byte is accepted in the same cycle
// as that last result is taken. Plain text runs at one byte per cycle when the
// receiver does not stall; multi-byte escapes hold input until fully taken.
// Reset returns the decoder to plain-text mode and empties the bundle.
// When the receiver stalls, the current result holds and req_chan.ready
// drops once the bundle cannot be refilled.
// ----------------------------------------------------------------------------
module json_string_unescaper_top
   import jsu_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   jsu_req_if.sink   req_chan,
   jsu_rsp_if.source rsp_chan
);

   dec_state_type state_ff, state_in;
   bundle_type    bundle_ff, bundle_in;
   logic [1:0]    idx_ff;
   logic          busy_ff;

   logic last_out;
   logic take;
   logic accept;

   jsu_decoder u_decoder (
      .cur_state     (state_ff),
      .in_byte       (req_chan.in_byte),
      .end_of_string (req_chan.end_of_string),
      .next_state    (state_in),
      .bundle        (bundle_in)
   );

   // The current slot is the last of the bundle.
   assign last_out = ({1'b0, idx_ff} == (bundle_ff.count - 3'd1));
   assign take     = busy_ff && rsp_chan.ready;
   assign accept   = req_chan.valid && req_chan.ready;

   // Take a new byte whenever the bundle is empty or is being drained now.
   assign req_chan.ready = !busy_ff || (rsp_chan.ready && last_out);

   assign rsp_chan.valid       = busy_ff;
   assign rsp_chan.out_byte    = bundle_ff.data[idx_ff];
   assign rsp_chan.byte_valid  = bundle_ff.valid[idx_ff];
   assign rsp_chan.status      = bundle_ff.status[idx_ff];
   assign rsp_chan.run_last    = last_out;
   assign rsp_chan.string_done = last_out && bundle_ff.eos;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
         busy_ff  <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         if (accept && bundle_in.count != 3'd0) begin
            busy_ff <= 1'b1;
            idx_ff  <= 2'd0;
         end else if (take) begin
            if (last_out) begin
               busy_ff <= 1'b0;
               idx_ff  <= 2'd0;
            end else begin
               idx_ff <= idx_ff + 2'd1;
            end
         end
      end
   end

   // The bundle payload needs no reset; busy_ff qualifies it.
   always_ff @(posedge clock) begin
      if (accept && bundle_in.count != 3'd0) begin
         bundle_ff <= bundle_in;
      end
   end

   // A held bundle always carries between one and four results.
   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (bundle_ff.count != 3'd0 && bundle_ff.count <= 3'd4))
      else $error("result bundle count out of range");

   // A new byte may overlap the output only when the last result leaves.
   assert property (@(posedge clock) disable iff (reset)
      (accept && busy_ff) |-> (take && last_out))
      else $error("input accepted over an undrained bundle");

   // The end of a string returns the decoder to its reset state.
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.end_of_string) |=> (state_ff == STATE_RESET))
      else $error("decoder state not cleared at end of string");

   // A pending error always holds one of the error codes in the mode field.
   assert property (@(posedge clock) disable iff (reset)
      state_ff.error_seen |-> (state_ff.mode == STATUS_BAD_ESC ||
                               state_ff.mode == STATUS_BAD_HEX ||
                               state_ff.mode == STATUS_SURROGATE))
      else $error("error flag set without an error code");

   // Every string end that is accepted leads to a string_done result.
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.end_of_string) |=> (busy_ff && bundle_ff.eos))
      else $error("end of string produced no final result");

endmodule
